// File: rtl/core/psdd_pkg.sv
package psdd_pkg;

    // Fixed speed and steering constants
    localparam int CRUISE_SPEED   = 600;
    localparam int LIMIT_SPEED    = 1100;
    localparam int STEER_GAIN     = 2;
    localparam int STEER_DEADBAND = 10;

    localparam int SPEED_W    = 12;
    localparam int ANGLE_W    = 13;
    localparam int DIST_W     = 13;
    localparam int MODE_W     = 3;
    localparam int CORR_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_APPROACH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PLAY     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PANIC    = 3'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_ANGLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERR_DEADBAND = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_INTEGRAL = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROP_GAIN    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTEG_GAIN   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_RANGE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_LOW     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_BAND_HIGH    = 3'd7;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] target_angle;
        logic [12:0]               err_deadband;
        logic [19:0]               max_integral;
        logic [15:0]               prop_gain;
        logic [15:0]               integ_gain;
        logic [DIST_W-1:0]         near_range_mm;
        logic [DIST_W-1:0]         band_low;
        logic [DIST_W-1:0]         band_high;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_angle:  13'sd0,
        err_deadband:  13'd16,
        max_integral:  20'd4096,
        prop_gain:     16'd512,
        integ_gain:    16'd16,
        near_range_mm: 13'd100,
        band_low:      13'd150,
        band_high:     13'd250
    };

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]         range_mm;
    } tick_t;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [DIST_W-1:0]        range_mm;
        logic signed [CORR_W-1:0] corr;
    } steer_t;

endpackage

// File: rtl/core/psdd_pi.sv
module psdd_pi (
    input  logic             clk,
    input  logic             rst_n,
    input  psdd_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  psdd_pkg::tick_t  in_tick,
    output logic             out_valid,
    input  logic             out_ready,
    output psdd_pkg::steer_t out_steer
);

    localparam int ERR_W   = psdd_pkg::ANGLE_W + 1;
    localparam int INTEG_W = 21;
    localparam int SUM_W   = INTEG_W + 1;
    localparam int PP_W    = 17 + ERR_W;
    localparam int PI_W    = 17 + INTEG_W;
    localparam int Q_W     = PI_W - 12;
    localparam int CORR_W  = psdd_pkg::CORR_W;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    psdd_pkg::tick_t tick1_reg;

    logic [psdd_pkg::MODE_W-1:0] mode2_reg;
    logic [psdd_pkg::DIST_W-1:0] dist2_reg;
    logic signed [PP_W-1:0]      prod_p_reg;
    logic signed [PI_W-1:0]      prod_i_reg;

    psdd_pkg::steer_t steer3_reg;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;

    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         err_mag;
    logic                     active;
    logic signed [SUM_W-1:0]  sum_wide;
    logic signed [SUM_W-1:0]  lim;
    logic signed [16:0]       gain_p;
    logic signed [16:0]       gain_i;
    logic signed [PP_W-1:0]   prod_p_next;
    logic signed [PI_W-1:0]   prod_i_next;

    logic signed [PI_W-1:0]   acc;
    logic signed [PI_W-1:0]   acc_adj;
    logic signed [Q_W-1:0]    q;
    logic signed [CORR_W-1:0] pi_sat;
    logic signed [CORR_W-1:0] corr_raw;
    logic [CORR_W-1:0]        corr_mag;
    logic signed [CORR_W-1:0] corr_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Error, deadband and clamped integral
    always_comb
    begin
        err      = ERR_W'(tick1_reg.angle) - ERR_W'(cfg.target_angle);
        err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        active   = err_mag >= ERR_W'(cfg.err_deadband);
        sum_wide = SUM_W'(integ_reg) + SUM_W'(err);
        lim      = $signed(SUM_W'(cfg.max_integral));
        if (sum_wide > lim)
        begin
            integ_next = INTEG_W'(lim);
        end
        else if (sum_wide < -lim)
        begin
            integ_next = INTEG_W'(-lim);
        end
        else
        begin
            integ_next = INTEG_W'(sum_wide);
        end
        gain_p      = $signed({1'b0, cfg.prop_gain});
        gain_i      = $signed({1'b0, cfg.integ_gain});
        prod_p_next = active ? PP_W'(gain_p) * PP_W'(err) : '0;
        prod_i_next = active ? PI_W'(gain_i) * PI_W'(integ_next) : '0;
    end

    // Sum, truncate toward zero, saturate, negate, drop small corrections
    always_comb
    begin
        acc     = PI_W'(prod_p_reg) + prod_i_reg;
        acc_adj = acc + (acc[PI_W-1] ? PI_W'(4095) : PI_W'(0));
        q       = acc_adj[PI_W-1:12];
        if (q > Q_W'(32767))
        begin
            pi_sat = 16'sh7FFF;
        end
        else if (q < -Q_W'(32768))
        begin
            pi_sat = 16'sh8000;
        end
        else
        begin
            pi_sat = q[CORR_W-1:0];
        end
        corr_raw  = (pi_sat == 16'sh8000) ? 16'sh7FFF : -pi_sat;
        corr_mag  = corr_raw[CORR_W-1] ? CORR_W'(-corr_raw) : CORR_W'(corr_raw);
        corr_next = (corr_mag < CORR_W'(psdd_pkg::STEER_DEADBAND)) ? '0 : corr_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            integ_reg <= '0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
                if (v1_reg && active)
                begin
                    integ_reg <= integ_next;
                end
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            tick1_reg <= in_tick;
        end
        if (rdy2 && v1_reg)
        begin
            mode2_reg  <= tick1_reg.mode;
            dist2_reg  <= tick1_reg.range_mm;
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
        end
        if (rdy3 && v2_reg)
        begin
            steer3_reg.mode     <= mode2_reg;
            steer3_reg.range_mm <= dist2_reg;
            steer3_reg.corr     <= corr_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_steer = steer3_reg;

endmodule

// File: rtl/core/psdd_drive.sv
module psdd_drive (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  psdd_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  psdd_pkg::steer_t                     in_steer,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [psdd_pkg::SPEED_W-1:0]  right_speed,
    output logic signed [psdd_pkg::SPEED_W-1:0]  left_speed,
    output logic                                 front_led,
    output logic                                 body_led,
    output logic [3:0]                           ring_leds
);

    localparam int STEER_W = psdd_pkg::CORR_W + 5;
    localparam int WHEEL_W = STEER_W + 1;
    localparam int SPEED_W = psdd_pkg::SPEED_W;

    localparam logic signed [WHEEL_W-1:0] CRUISE = WHEEL_W'(psdd_pkg::CRUISE_SPEED);
    localparam logic signed [WHEEL_W-1:0] LIMIT  = WHEEL_W'(psdd_pkg::LIMIT_SPEED);
    localparam logic signed [STEER_W-1:0] GAIN   = STEER_W'(psdd_pkg::STEER_GAIN);

    function automatic logic signed [SPEED_W-1:0] sat_wheel(input logic signed [WHEEL_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > LIMIT)
        begin
            r = SPEED_W'(LIMIT);
        end
        else if (v < -LIMIT)
        begin
            r = SPEED_W'(-LIMIT);
        end
        else
        begin
            r = SPEED_W'(v);
        end
        return r;
    endfunction

    logic                      v_reg;
    logic                      rdy;
    logic signed [SPEED_W-1:0] right_reg, left_reg, right_next, left_next;
    logic signed [SPEED_W-1:0] right_hold_reg;
    logic                      front_reg, body_reg, front_next, body_next;
    logic [3:0]                ring_reg, ring_next;

    logic signed [STEER_W-1:0] steer;
    logic signed [WHEEL_W-1:0] right_raw, left_raw;
    logic                      far;
    logic                      in_band;

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_comb
    begin
        steer      = GAIN * STEER_W'(in_steer.corr);
        far        = in_steer.range_mm >= cfg.near_range_mm;
        in_band    = (in_steer.range_mm >= cfg.band_low) && (in_steer.range_mm <= cfg.band_high);
        right_raw  = '0;
        left_raw   = '0;
        front_next = 1'b0;
        body_next  = 1'b0;
        ring_next  = 4'h0;
        unique case (in_steer.mode)
            psdd_pkg::MODE_APPROACH:
            begin
                front_next = 1'b1;
                if (far)
                begin
                    right_raw = CRUISE - WHEEL_W'(steer);
                    left_raw  = CRUISE + WHEEL_W'(steer);
                end
                else
                begin
                    right_raw = LIMIT;
                    left_raw  = LIMIT;
                    ring_next = 4'hF;
                end
            end
            psdd_pkg::MODE_PLAY:
            begin
                if (in_band)
                begin
                    right_raw = '0;
                    left_raw  = '0;
                end
                else if (far)
                begin
                    right_raw = CRUISE - WHEEL_W'(steer);
                    left_raw  = CRUISE + WHEEL_W'(steer);
                end
                else
                begin
                    right_raw = -CRUISE - WHEEL_W'(steer);
                    left_raw  = -CRUISE + WHEEL_W'(steer);
                end
            end
            psdd_pkg::MODE_PANIC:
            begin
                right_raw = WHEEL_W'(right_hold_reg);
                left_raw  = LIMIT;
                body_next = 1'b1;
            end
            default:
            begin
                right_raw = '0;
                left_raw  = '0;
            end
        endcase
        right_next = sat_wheel(right_raw);
        left_next  = sat_wheel(left_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg          <= 1'b0;
            right_hold_reg <= '0;
        end
        else if (rdy)
        begin
            v_reg <= in_valid;
            if (in_valid)
            begin
                right_hold_reg <= right_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
        begin
            right_reg <= right_next;
            left_reg  <= left_next;
            front_reg <= front_next;
            body_reg  <= body_next;
            ring_reg  <= ring_next;
        end
    end

    assign out_valid   = v_reg;
    assign right_speed = right_reg;
    assign left_speed  = left_reg;
    assign front_led   = front_reg;
    assign body_led    = body_reg;
    assign ring_leds   = ring_reg;

endmodule

// File: rtl/core/pi_steer_differential_drive.sv
// PI steering controller for a two-wheeled robot, one control tick per transfer.
//
// Input stream (s_tvalid/s_tready/s_tdata): one tick carrying mode, measured
// source angle and range reading. Output stream (m_tvalid/m_tready/m_tdata):
// one result per tick with both wheel commands and the LED states.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
// the block must be idle while its registers change.
//
// Path: a tick accepted on the input stream passes the input register, gain
// products, correction and output register before its result shows on m_tdata.
// Throughput: one tick per cycle while m_tready is high, set by the four-stage
// pipeline; integral updates never make consecutive ticks wait.
//
// Reset clears the pipeline, the integral and the held right wheel command,
// and loads the register defaults. When the receiver stalls, the result
// holds on m_tdata and the stages behind it keep filling; s_tready drops only
// once every stage holds a tick.
module pi_steer_differential_drive (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // mode, angle, distance_mm, zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // right_speed, left_speed, front_led,
                                                           // body_led, ring_leds, zero pad
    input  logic                                cfg_we,
    input  logic [psdd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [psdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    psdd_pkg::cfg_t   cfg_reg;
    psdd_pkg::tick_t  tick;
    psdd_pkg::steer_t steer;
    logic             steer_valid;
    logic             steer_ready;

    logic signed [psdd_pkg::SPEED_W-1:0] right_speed;
    logic signed [psdd_pkg::SPEED_W-1:0] left_speed;
    logic                                front_led;
    logic                                body_led;
    logic [3:0]                          ring_leds;

    // Configuration registers: each write lands in one field, truncated to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= psdd_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                psdd_pkg::CFG_TARGET_ANGLE: cfg_reg.target_angle  <= $signed(cfg_wdata[12:0]);
                psdd_pkg::CFG_ERR_DEADBAND: cfg_reg.err_deadband  <= cfg_wdata[12:0];
                psdd_pkg::CFG_MAX_INTEGRAL: cfg_reg.max_integral  <= cfg_wdata[19:0];
                psdd_pkg::CFG_PROP_GAIN:    cfg_reg.prop_gain     <= cfg_wdata[15:0];
                psdd_pkg::CFG_INTEG_GAIN:   cfg_reg.integ_gain    <= cfg_wdata[15:0];
                psdd_pkg::CFG_NEAR_RANGE:   cfg_reg.near_range_mm <= cfg_wdata[12:0];
                psdd_pkg::CFG_BAND_LOW:     cfg_reg.band_low      <= cfg_wdata[12:0];
                psdd_pkg::CFG_BAND_HIGH:    cfg_reg.band_high     <= cfg_wdata[12:0];
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Unpack the tick: mode in the lowest bits, then angle, then distance
    assign tick.mode     = s_tdata[2:0];
    assign tick.angle    = $signed(s_tdata[15:3]);
    assign tick.range_mm = s_tdata[28:16];

    // Regulator: input register, gain products, correction
    psdd_pi u_pi (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_tick   (tick),
        .out_valid (steer_valid),
        .out_ready (steer_ready),
        .out_steer (steer)
    );

    // Wheel mixing by mode, saturation and the output register
    psdd_drive u_drive (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (steer_valid),
        .in_ready    (steer_ready),
        .in_steer    (steer),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .right_speed (right_speed),
        .left_speed  (left_speed),
        .front_led   (front_led),
        .body_led    (body_led),
        .ring_leds   (ring_leds)
    );

    // Pack the result, right wheel in the lowest bits, pad to 32
    assign m_tdata = {2'b00, ring_leds, body_led, front_led, left_speed, right_speed};

endmodule

// File: rtl/core/psdd_checker.sv
module psdd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    localparam logic signed [psdd_pkg::SPEED_W-1:0] LIM = psdd_pkg::SPEED_W'(psdd_pkg::LIMIT_SPEED);

    logic signed [psdd_pkg::SPEED_W-1:0] right_speed;
    logic signed [psdd_pkg::SPEED_W-1:0] left_speed;
    logic                                front_led;
    logic                                body_led;
    logic [3:0]                          ring_leds;
    logic                                in_seen;

    assign right_speed = $signed(m_tdata[11:0]);
    assign left_speed  = $signed(m_tdata[23:12]);
    assign front_led   = m_tdata[24];
    assign body_led    = m_tdata[25];
    assign ring_leds   = m_tdata[29:26];
    assign in_seen     = s_tvalid && s_tready && (s_tdata[31:29] == 3'b000 || s_tdata[31:29] != 3'b000);

    // No result in the cycle after a reset cycle
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result shown during reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Wheel commands stay within the speed limit
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> right_speed <= LIM && right_speed >= -LIM
                  && left_speed <= LIM && left_speed >= -LIM)
        else $error("wheel command beyond limit");

    // Ring LEDs light only all together, in approach mode at full speed
    a_ring_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ring_leds != 4'h0 |-> ring_leds == 4'hF && front_led && !body_led
                  && left_speed == LIM && right_speed == LIM)
        else $error("ring LEDs inconsistent with close approach");

    // Front and body LEDs belong to different modes
    a_led_modes: assert property (@(posedge clk) disable iff (!rst_n || !in_seen && !m_tvalid)
        m_tvalid |-> !(front_led && body_led))
        else $error("front and body LEDs both lit");

endmodule

bind pi_steer_differential_drive psdd_checker u_psdd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/pi_steer_differential_drive_tb.sv
`timescale 1ns / 100ps

module pi_steer_differential_drive_tb;

    // Cycles from an accepted tick to its result on the output stream
    localparam int PIPE_LATENCY = 3;

    // One wheel command as packed on m_tdata, highest field first
    typedef struct packed {
        logic [3:0]         ring_leds;
        logic               body_led;
        logic               front_led;
        logic signed [11:0] left_speed;
        logic signed [11:0] right_speed;
    } wheel_cmd_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;    // mode, angle, distance_mm, zero pad
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;    // right_speed, left_speed, front_led,
                                                 // body_led, ring_leds, zero pad
    logic                            cfg_we;
    logic [psdd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [psdd_pkg::CFG_DATA_W-1:0] cfg_wdata;

    // Shadow of the register file and of the controller state
    psdd_pkg::cfg_t cfg_shadow;
    int             integ_acc;
    int             right_hold_q;
    wheel_cmd_t     expected_cmds[$];
    int             mismatch_count;
    bit             no_idle;

    pi_steer_differential_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the stream locks up
    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

    // Work out the wheel command for one tick and advance the shadow state.
    // The integral only moves when the error is outside the deadband.
    function automatic wheel_cmd_t predict_wheel_cmd(input logic [2:0] mode,
                                                     input logic signed [12:0] angle,
                                                     input logic [12:0] range_mm);
        int         err;
        int         mag;
        int         lim;
        int         sum;
        int         reg_out;
        int         corr;
        int         steer;
        int         right;
        int         left;
        int         d;
        longint     kp;
        longint     ki;
        longint     acc;
        longint     q;
        wheel_cmd_t cmd;
        err = int'(angle) - int'($signed(cfg_shadow.target_angle));
        mag = (err < 0) ? -err : err;
        d = int'(range_mm);
        reg_out = 0;
        if (mag >= int'(cfg_shadow.err_deadband))
        begin
            lim = int'(cfg_shadow.max_integral);
            sum = integ_acc + err;
            if (sum > lim)
                sum = lim;
            else if (sum < -lim)
                sum = -lim;
            integ_acc = sum;
            kp = cfg_shadow.prop_gain;
            ki = cfg_shadow.integ_gain;
            acc = kp * err + ki * sum;
            // signed division truncates toward zero
            q = acc / 4096;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            reg_out = int'(q);
        end
        // negating the most negative regulator value pins to the top
        corr = (reg_out == -32768) ? 32767 : -reg_out;
        if (((corr < 0) ? -corr : corr) < psdd_pkg::STEER_DEADBAND)
            corr = 0;
        steer = psdd_pkg::STEER_GAIN * corr;
        cmd = '0;
        case (mode)
            psdd_pkg::MODE_APPROACH:
            begin
                cmd.front_led = 1'b1;
                if (d >= int'(cfg_shadow.near_range_mm))
                begin
                    right = psdd_pkg::CRUISE_SPEED - steer;
                    left = psdd_pkg::CRUISE_SPEED + steer;
                end
                else
                begin
                    right = psdd_pkg::LIMIT_SPEED;
                    left = psdd_pkg::LIMIT_SPEED;
                    cmd.ring_leds = 4'hF;
                end
            end
            psdd_pkg::MODE_PLAY:
            begin
                // an inverted band never matches
                if (d >= int'(cfg_shadow.band_low) && d <= int'(cfg_shadow.band_high))
                begin
                    right = 0;
                    left = 0;
                end
                else if (d >= int'(cfg_shadow.near_range_mm))
                begin
                    right = psdd_pkg::CRUISE_SPEED - steer;
                    left = psdd_pkg::CRUISE_SPEED + steer;
                end
                else
                begin
                    right = -psdd_pkg::CRUISE_SPEED - steer;
                    left = -psdd_pkg::CRUISE_SPEED + steer;
                end
            end
            psdd_pkg::MODE_PANIC:
            begin
                right = right_hold_q;
                left = psdd_pkg::LIMIT_SPEED;
                cmd.body_led = 1'b1;
            end
            default:
            begin
                right = 0;
                left = 0;
            end
        endcase
        if (right > psdd_pkg::LIMIT_SPEED)
            right = psdd_pkg::LIMIT_SPEED;
        if (right < -psdd_pkg::LIMIT_SPEED)
            right = -psdd_pkg::LIMIT_SPEED;
        if (left > psdd_pkg::LIMIT_SPEED)
            left = psdd_pkg::LIMIT_SPEED;
        if (left < -psdd_pkg::LIMIT_SPEED)
            left = -psdd_pkg::LIMIT_SPEED;
        right_hold_q = right;
        cmd.right_speed = 12'(right);
        cmd.left_speed = 12'(left);
        return cmd;
    endfunction

    // Receiver side: drop tready about 30% of the time unless idling is off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Compare every result transfer with the oldest outstanding command
    always @(posedge clk)
    begin
        wheel_cmd_t actual_cmd;
        wheel_cmd_t expected_cmd;
        if (rst_n && m_tvalid && m_tready)
        begin
            actual_cmd = wheel_cmd_t'(m_tdata[29:0]);
            if (expected_cmds.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                expected_cmd = expected_cmds.pop_front();
                report_field("right_speed", expected_cmd.right_speed,
                             actual_cmd.right_speed);
                report_field("left_speed", expected_cmd.left_speed,
                             actual_cmd.left_speed);
                report_field("front_led", expected_cmd.front_led, actual_cmd.front_led);
                report_field("body_led", expected_cmd.body_led, actual_cmd.body_led);
                report_field("ring_leds", expected_cmd.ring_leds, actual_cmd.ring_leds);
            end
        end
    end

    // Offer one tick, hold it until the transfer, then log its prediction.
    // Insert a short gap before it about 30% of the time.
    task automatic send_tick(input logic [2:0] mode, input int angle, input int range_mm);
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, 13'(range_mm), 13'(angle), mode};
        do
            @(posedge clk);
        while (!s_tready);
        expected_cmds.push_back(predict_wheel_cmd(mode, 13'(angle), 13'(range_mm)));
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipe empty
    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [psdd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [psdd_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
    endtask

    // Load a full register set once the block is idle
    task automatic apply_config(input psdd_pkg::cfg_t c);
        settle_idle();
        write_reg(psdd_pkg::CFG_TARGET_ANGLE, psdd_pkg::CFG_DATA_W'(c.target_angle));
        write_reg(psdd_pkg::CFG_ERR_DEADBAND, psdd_pkg::CFG_DATA_W'(c.err_deadband));
        write_reg(psdd_pkg::CFG_MAX_INTEGRAL, c.max_integral);
        write_reg(psdd_pkg::CFG_PROP_GAIN, psdd_pkg::CFG_DATA_W'(c.prop_gain));
        write_reg(psdd_pkg::CFG_INTEG_GAIN, psdd_pkg::CFG_DATA_W'(c.integ_gain));
        write_reg(psdd_pkg::CFG_NEAR_RANGE, psdd_pkg::CFG_DATA_W'(c.near_range_mm));
        write_reg(psdd_pkg::CFG_BAND_LOW, psdd_pkg::CFG_DATA_W'(c.band_low));
        write_reg(psdd_pkg::CFG_BAND_HIGH, psdd_pkg::CFG_DATA_W'(c.band_high));
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_shadow = c;
    endtask

    // Pick a value in range, landing on either end an eighth of the time each
    function automatic int pick_range(input int lo, input int hi);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return lo;
        if (sel == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic psdd_pkg::cfg_t random_config();
        psdd_pkg::cfg_t c;
        c.target_angle = 13'(pick_range(-2880, 2880));
        c.err_deadband = 13'(($urandom_range(0, 3) == 0) ? pick_range(0, 5760)
                                                          : pick_range(0, 40));
        c.max_integral = 20'($urandom_range(0, 1) ? pick_range(0, 1048575)
                                                  : pick_range(0, 20000));
        c.prop_gain = 16'($urandom_range(0, 1) ? pick_range(0, 65535) : pick_range(0, 2048));
        c.integ_gain = 16'($urandom_range(0, 1) ? pick_range(0, 65535) : pick_range(0, 256));
        c.near_range_mm = 13'($urandom_range(0, 1) ? pick_range(0, 8191) : pick_range(0, 600));
        c.band_low = 13'($urandom_range(0, 1) ? pick_range(0, 8191) : pick_range(0, 600));
        c.band_high = 13'($urandom_range(0, 1) ? pick_range(0, 8191) : pick_range(0, 600));
        return c;
    endfunction

    // The three active mode codes and idle codes 0, 4 and 7, under the reset registers
    task automatic test_mode_decode();
        send_tick(3'd0, 800, 500);
        send_tick(psdd_pkg::MODE_APPROACH, 800, 500);
        send_tick(psdd_pkg::MODE_APPROACH, -300, 50);
        send_tick(psdd_pkg::MODE_PLAY, 20, 200);
        send_tick(psdd_pkg::MODE_PLAY, -1200, 120);
        send_tick(psdd_pkg::MODE_PANIC, 5, 3000);
        send_tick(3'd4, 2880, 8191);
        send_tick(3'd7, -2880, 0);
    endtask

    // Field extremes with every register at one of its limits
    task automatic test_field_extremes();
        psdd_pkg::cfg_t c;
        c = '{target_angle: -13'sd2880, err_deadband: 13'd0, max_integral: 20'hFFFFF,
              prop_gain: 16'hFFFF, integ_gain: 16'hFFFF, near_range_mm: 13'd8191,
              band_low: 13'd8191, band_high: 13'd0};
        apply_config(c);
        send_tick(psdd_pkg::MODE_APPROACH, 2880, 8191);
        send_tick(psdd_pkg::MODE_PLAY, -2880, 0);
        send_tick(psdd_pkg::MODE_APPROACH, 2880, 0);
        send_tick(psdd_pkg::MODE_PLAY, 0, 8191);
        send_tick(psdd_pkg::MODE_PANIC, 2880, 8191);
    endtask

    // Regulator pinned at its most negative value, so the negation saturates
    task automatic test_negation_overflow();
        psdd_pkg::cfg_t c;
        c = psdd_pkg::CFG_RESET;
        c.err_deadband = 13'd0;
        c.max_integral = 20'd0;
        c.prop_gain = 16'hFFFF;
        c.integ_gain = 16'd0;
        c.near_range_mm = 13'd0;
        apply_config(c);
        send_tick(psdd_pkg::MODE_APPROACH, -2880, 500);
        send_tick(psdd_pkg::MODE_APPROACH, 2880, 500);
        send_tick(psdd_pkg::MODE_PLAY, -1, 500);
    endtask

    // Inverted stop band never stops the wheels in play mode
    task automatic test_stop_band();
        psdd_pkg::cfg_t c;
        c = psdd_pkg::CFG_RESET;
        c.band_low = 13'd300;
        c.band_high = 13'd200;
        c.near_range_mm = 13'd250;
        apply_config(c);
        send_tick(psdd_pkg::MODE_PLAY, 100, 200);
        send_tick(psdd_pkg::MODE_PLAY, 100, 250);
        send_tick(psdd_pkg::MODE_PLAY, -100, 300);
        send_tick(psdd_pkg::MODE_PLAY, -100, 100);
    endtask

    // Error just inside and on the deadband, and corrections small enough to zero
    task automatic test_deadband_edges();
        psdd_pkg::cfg_t c;
        c = psdd_pkg::CFG_RESET;
        c.target_angle = 13'sd100;
        c.err_deadband = 13'd20;
        c.prop_gain = 16'd1024;
        c.integ_gain = 16'd0;
        apply_config(c);
        send_tick(psdd_pkg::MODE_APPROACH, 119, 1000);
        send_tick(psdd_pkg::MODE_APPROACH, 120, 1000);
        send_tick(psdd_pkg::MODE_APPROACH, 139, 1000);
        send_tick(psdd_pkg::MODE_APPROACH, 60, 1000);
    endtask

    // Random ticks over a series of register sets; one phase runs without gaps
    task automatic test_random_ticks();
        psdd_pkg::cfg_t c;
        int             angle;
        int             range_mm;
        int             thr;
        int             sel;
        logic [2:0]     mode;
        for (int phase = 0; phase < 12; phase++)
        begin
            c = (phase == 0) ? psdd_pkg::CFG_RESET : random_config();
            apply_config(c);
            no_idle = (phase == 5);
            for (int n = 0; n < 125; n++)
            begin
                // mostly the three active modes, some idle codes
                mode = ($urandom_range(0, 9) < 3) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 3));
                // aim at the deadband edge now and then
                thr = int'(c.err_deadband);
                if ($urandom_range(0, 3) == 0)
                    angle = int'($signed(c.target_angle)) +
                            ($urandom_range(0, 1) ? thr : -thr) + $urandom_range(0, 2) - 1;
                else
                    angle = pick_range(-2880, 2880);
                if (angle > 2880)
                    angle = 2880;
                if (angle < -2880)
                    angle = -2880;
                // distances around each threshold, otherwise anywhere
                sel = $urandom_range(0, 5);
                case (sel)
                    0: range_mm = int'(c.near_range_mm) + $urandom_range(0, 4) - 2;
                    1: range_mm = int'(c.band_low) + $urandom_range(0, 4) - 2;
                    2: range_mm = int'(c.band_high) + $urandom_range(0, 4) - 2;
                    3: range_mm = pick_range(0, 600);
                    default: range_mm = pick_range(0, 8191);
                endcase
                if (range_mm > 8191)
                    range_mm = 8191;
                if (range_mm < 0)
                    range_mm = 0;
                send_tick(mode, angle, range_mm);
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        no_idle = 1'b0;
        mismatch_count = 0;
        integ_acc = 0;
        right_hold_q = 0;
        cfg_shadow = psdd_pkg::CFG_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_mode_decode();
        test_field_extremes();
        test_negation_overflow();
        test_stop_band();
        test_deadband_edges();
        test_random_ticks();

        // wait out the last results and a few spare cycles for strays
        settle_idle();
        if (mismatch_count == 0 && expected_cmds.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
